### hdl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Implication whose consequent must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    `ASSERT_PROP(lbl, clk, rst_n, (pre) |=> (post))

`endif

### hdl/gvp_pkg.sv
// Types, constants and tables for the grid vector to polar converter.
package gvp_pkg;

    localparam int COORD_WIDTH = 8;
    localparam int FRAC_BITS   = 8;

    localparam int DELTA_W  = COORD_WIDTH + 1;
    localparam int SUMSQ_W  = 2 * COORD_WIDTH + 1;
    localparam int ROOT_W   = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int MAG_W    = ROOT_W;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 3;
    localparam int SQRT_STEPS = ROOT_W;

    localparam int PRESHIFT     = 30;
    localparam int X_W          = COORD_WIDTH + PRESHIFT + 4;
    localparam int ANG_SCALE    = 24;
    localparam int ATAN_W       = 30;
    localparam int Z_W          = 33;
    localparam int ZC_W         = 31;
    localparam int ANG_W        = 15;
    localparam int CORDIC_STEPS = 26;
    localparam int STEP_W       = 5;
    localparam int ANG_SH       = ANG_SCALE - FRAC_BITS;

    // 90 degrees in accumulator units
    localparam logic [ZC_W-1:0] ANG_TOP = ZC_W'(90) << ANG_SCALE;
    localparam logic [ANG_W-1:0] ANG_RIGHT = ANG_W'(90) << FRAC_BITS;

    // atan(2^-i) in degrees, 2^-24 degree units
    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115,
        30'd57,        30'd29
    };

    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic                      ax_zero;
        logic                      ay_zero;
        logic signed [X_W-1:0]     x;
        logic signed [X_W-1:0]     y;
        logic signed [Z_W-1:0]     z;
        logic [REM_W-1:0]          rem;
        logic [ROOT_W-1:0]         root;
        logic [RAD_W-1:0]          rad;
    } gvp_stage_t;

endpackage

### hdl/gvp_prep.sv
// Input stage: differences, absolute values, sum of squares, CORDIC seed.
module gvp_prep (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [gvp_pkg::COORD_WIDTH-1:0] origin_x,
    input  logic [gvp_pkg::COORD_WIDTH-1:0] origin_y,
    input  logic [gvp_pkg::COORD_WIDTH-1:0] dest_x,
    input  logic [gvp_pkg::COORD_WIDTH-1:0] dest_y,
    output logic                         out_valid,
    output gvp_pkg::gvp_stage_t          out_data
);
    import gvp_pkg::*;

    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [COORD_WIDTH-1:0]    ax;
    logic [COORD_WIDTH-1:0]    ay;
    logic [2*COORD_WIDTH-1:0]  ax_sq;
    logic [2*COORD_WIDTH-1:0]  ay_sq;
    logic [SUMSQ_W-1:0]        sumsq;
    gvp_stage_t                data_next;
    gvp_stage_t                data_reg;
    logic                      valid_reg;

    always_comb begin
        dx = $signed({1'b0, dest_x}) - $signed({1'b0, origin_x});
        dy = $signed({1'b0, dest_y}) - $signed({1'b0, origin_y});
        ax = dx[DELTA_W-1] ? COORD_WIDTH'(-dx) : COORD_WIDTH'(dx);
        ay = dy[DELTA_W-1] ? COORD_WIDTH'(-dy) : COORD_WIDTH'(dy);
        ax_sq = ax * ax;
        ay_sq = ay * ay;
        sumsq = SUMSQ_W'(ax_sq) + SUMSQ_W'(ay_sq);

        data_next.dx      = dx;
        data_next.dy      = dy;
        data_next.ax_zero = (ax == '0);
        data_next.ay_zero = (ay == '0);
        data_next.x       = $signed({{(X_W-COORD_WIDTH-PRESHIFT){1'b0}}, ax,
                                     {PRESHIFT{1'b0}}});
        data_next.y       = $signed({{(X_W-COORD_WIDTH-PRESHIFT){1'b0}}, ay,
                                     {PRESHIFT{1'b0}}});
        data_next.z       = '0;
        data_next.rem     = '0;
        data_next.root    = '0;
        data_next.rad     = RAD_W'(sumsq) << (2 * FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### hdl/gvp_cell.sv
// One pipeline cell: a CORDIC vectoring step and, when sqrt_en is set, a square root digit step.
module gvp_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [gvp_pkg::STEP_W-1:0]   step,
    input  logic                         sqrt_en,
    input  logic                         in_valid,
    input  gvp_pkg::gvp_stage_t          in_data,
    output logic                         out_valid,
    output gvp_pkg::gvp_stage_t          out_data
);
    import gvp_pkg::*;

    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] ys;
    logic signed [Z_W-1:0] atan_ext;
    logic [REM_W-1:0]      trial;
    logic [REM_W-1:0]      test;
    gvp_stage_t            data_next;
    gvp_stage_t            data_reg;
    logic                  valid_reg;

    assign atan_ext = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_TAB[step]});

    always_comb begin
        data_next = in_data;
        // arithmetic shift rounds toward minus infinity
        xs = in_data.x >>> step;
        ys = in_data.y >>> step;
        if (!in_data.y[X_W-1]) begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + atan_ext;
        end else begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - atan_ext;
        end

        // restoring square root, two radicand bits per step
        trial = {in_data.rem[REM_W-3:0], in_data.rad[RAD_W-1 -: 2]};
        test  = REM_W'({in_data.root, 2'b01});
        if (sqrt_en) begin
            data_next.rad = in_data.rad << 2;
            if (trial >= test) begin
                data_next.rem  = trial - test;
                data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
            end else begin
                data_next.rem  = trial;
                data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### hdl/gvp_finish.sv
// Output stage: magnitude rounding, angle clamp and rounding, special cases.
module gvp_finish (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  gvp_pkg::gvp_stage_t                in_data,
    output logic                               out_valid,
    output logic signed [gvp_pkg::DELTA_W-1:0] delta_x,
    output logic signed [gvp_pkg::DELTA_W-1:0] delta_y,
    output logic [gvp_pkg::MAG_W-1:0]          magnitude,
    output logic [gvp_pkg::ANG_W-1:0]          angle_degrees,
    output logic                               zero_vector
);
    import gvp_pkg::*;

    logic                      zero;
    logic [ZC_W-1:0]           zc;
    logic [ZC_W:0]             zsum;
    logic [MAG_W-1:0]          mag_next;
    logic [ANG_W-1:0]          ang_next;
    logic                      valid_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [ANG_W-1:0]          ang_reg;
    logic                      zero_reg;

    always_comb begin
        zero = in_data.ax_zero && in_data.ay_zero;

        if (in_data.z[Z_W-1]) begin
            zc = '0;
        end else if (in_data.z[Z_W-2:0] > (Z_W-1)'(ANG_TOP)) begin
            zc = ANG_TOP;
        end else begin
            zc = in_data.z[ZC_W-1:0];
        end
        zsum = {1'b0, zc} + (ZC_W + 1)'(1 << (ANG_SH - 1));

        // round up when the remainder exceeds the floor root
        if (zero) begin
            mag_next = '0;
        end else if (in_data.rem > REM_W'(in_data.root)) begin
            mag_next = in_data.root + MAG_W'(1);
        end else begin
            mag_next = in_data.root;
        end

        if (zero || in_data.ay_zero) begin
            ang_next = '0;
        end else if (in_data.ax_zero) begin
            ang_next = ANG_RIGHT;
        end else begin
            ang_next = zsum[ANG_SH +: ANG_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg   <= in_data.dx;
            dy_reg   <= in_data.dy;
            mag_reg  <= mag_next;
            ang_reg  <= ang_next;
            zero_reg <= zero;
        end
    end

    assign out_valid     = valid_reg;
    assign delta_x       = dx_reg;
    assign delta_y       = dy_reg;
    assign magnitude     = mag_reg;
    assign angle_degrees = ang_reg;
    assign zero_vector   = zero_reg;

endmodule

### hdl/grid_vector_to_polar.sv
// Grid vector to polar: difference vector, length and reference angle of two grid points.
// Fully pipelined: one transaction is accepted per clock unless the output stalls; it passes
// through one input stage, a chain of 26 cells each doing one CORDIC vectoring step and,
// in the first 17, one square-root digit, then one output register. When the output
// transaction is not taken, the whole chain holds and s_ready drops in the same cycle;
// s_ready is high whenever the output register is empty or being read.
// Magnitude and angle carry 8 fraction bits; the angle lies from 0 to 90 degrees and is
// 0 with zero_vector set when both points coincide.
module grid_vector_to_polar (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [gvp_pkg::COORD_WIDTH-1:0]    s_origin_x,
    input  logic [gvp_pkg::COORD_WIDTH-1:0]    s_origin_y,
    input  logic [gvp_pkg::COORD_WIDTH-1:0]    s_dest_x,
    input  logic [gvp_pkg::COORD_WIDTH-1:0]    s_dest_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [gvp_pkg::DELTA_W-1:0] m_delta_x,
    output logic signed [gvp_pkg::DELTA_W-1:0] m_delta_y,
    output logic [gvp_pkg::MAG_W-1:0]          m_magnitude,
    output logic [gvp_pkg::ANG_W-1:0]          m_angle_degrees,
    output logic                               m_zero_vector
);
    import gvp_pkg::*;

    logic       adv;
    logic       valid_chain [CORDIC_STEPS+1];
    gvp_stage_t data_chain  [CORDIC_STEPS+1];

    // chain advances whenever the output register can take a new transaction
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    gvp_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .origin_x  (s_origin_x),
        .origin_y  (s_origin_y),
        .dest_x    (s_dest_x),
        .dest_y    (s_dest_y),
        .out_valid (valid_chain[0]),
        .out_data  (data_chain[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        gvp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .step      (STEP_W'(i)),
            .sqrt_en   ((i < SQRT_STEPS) ? 1'b1 : 1'b0),
            .in_valid  (valid_chain[i]),
            .in_data   (data_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_data  (data_chain[i+1])
        );
    end

    gvp_finish u_finish (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (adv),
        .in_valid      (valid_chain[CORDIC_STEPS]),
        .in_data       (data_chain[CORDIC_STEPS]),
        .out_valid     (m_valid),
        .delta_x       (m_delta_x),
        .delta_y       (m_delta_y),
        .magnitude     (m_magnitude),
        .angle_degrees (m_angle_degrees),
        .zero_vector   (m_zero_vector)
    );

endmodule

### hdl/gvp_checker.sv
// Port-level checker for the grid vector to polar converter, with its bind.
`include "assert_macros.svh"

module gvp_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [gvp_pkg::DELTA_W-1:0] m_delta_x,
    input logic signed [gvp_pkg::DELTA_W-1:0] m_delta_y,
    input logic [gvp_pkg::MAG_W-1:0]          m_magnitude,
    input logic [gvp_pkg::ANG_W-1:0]          m_angle_degrees,
    input logic                               m_zero_vector
);
    import gvp_pkg::*;

    localparam int OUT_W = 2 * DELTA_W + MAG_W + ANG_W + 1;

    logic [OUT_W-1:0] out_bus;
    logic             dxy_zero;
    logic             polar_zero;
    logic             vertical;

    assign out_bus    = {m_delta_x, m_delta_y, m_magnitude, m_angle_degrees, m_zero_vector};
    assign dxy_zero   = (m_delta_x == '0) && (m_delta_y == '0);
    assign polar_zero = (m_magnitude == '0) && (m_angle_degrees == '0);
    assign vertical   = m_valid && (m_delta_x == '0) && (m_delta_y != '0);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_bus))

    // input side only backs up while a result is held
    `ASSERT_PROP(a_ready_stall, aclk, aresetn, !s_ready |-> (m_valid && !m_ready))

    `ASSERT_PROP(a_zero_flag, aclk, aresetn, m_valid |-> (m_zero_vector == dxy_zero))

    `ASSERT_PROP(a_zero_out, aclk, aresetn, (m_valid && m_zero_vector) |-> polar_zero)

    `ASSERT_PROP(a_vertical, aclk, aresetn, vertical |-> (m_angle_degrees == ANG_RIGHT))

endmodule

bind grid_vector_to_polar gvp_checker u_gvp_checker (.*);

### tb/sv/grid_vector_to_polar_test.sv
// Self-checking testbench for the grid vector to polar converter.
`timescale 1ns / 1ps

module grid_vector_to_polar_test;

    localparam int CW   = gvp_pkg::COORD_WIDTH;
    localparam int FRAC = gvp_pkg::FRAC_BITS;

    // CORDIC setup: 26 vectoring steps, angle in 2^-24 degree, operands pre-scaled by 2^30
    localparam int ROT_STEPS = 26;
    localparam int Z_FRAC    = 24;
    localparam int PRE_SCALE = 30;

    typedef struct {
        logic signed [gvp_pkg::DELTA_W-1:0] delta_x;
        logic signed [gvp_pkg::DELTA_W-1:0] delta_y;
        logic [gvp_pkg::MAG_W-1:0]          magnitude;
        logic [gvp_pkg::ANG_W-1:0]          angle_degrees;
        logic                               zero_vector;
    } polar_t;

    class polar_scoreboard;
        polar_t pending_polar[$];
        int     fail_count;
        longint atan_q24[ROT_STEPS];

        function new();
            fail_count = 0;
            atan_q24 = '{
                754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                15018523, 7509720, 3754917, 1877466, 938734, 469367,
                234684, 117342, 58671, 29335, 14668, 7334,
                3667, 1833, 917, 458, 229, 115, 57, 29
            };
        endfunction

        function polar_t predict_polar(logic [CW-1:0] ox, logic [CW-1:0] oy,
                                       logic [CW-1:0] px, logic [CW-1:0] py);
            polar_t              res;
            longint              ox_i, oy_i, px_i, py_i, ddx, ddy, ax, ay;
            longint unsigned     sq, root, rest, probe;
            longint              x, y, z, xs, ys;
            longint unsigned     uz;
            ox_i = ox;
            oy_i = oy;
            px_i = px;
            py_i = py;
            ddx = px_i - ox_i;
            ddy = py_i - oy_i;
            ax = (ddx < 0) ? -ddx : ddx;
            ay = (ddy < 0) ? -ddy : ddy;
            res.delta_x     = ddx[gvp_pkg::DELTA_W-1:0];
            res.delta_y     = ddy[gvp_pkg::DELTA_W-1:0];
            res.zero_vector = (ax == 0 && ay == 0);
            res.magnitude     = '0;
            res.angle_degrees = '0;
            if (!res.zero_vector) begin
                // bitwise integer square root, then round to nearest
                sq = longint'(ax * ax + ay * ay) << (2 * FRAC);
                root = 0;
                rest = sq;
                probe = 64'd1 << 62;
                while (probe > rest) probe >>= 2;
                while (probe != 0) begin
                    if (rest >= root + probe) begin
                        rest -= root + probe;
                        root = (root >> 1) + probe;
                    end else begin
                        root >>= 1;
                    end
                    probe >>= 2;
                end
                if (rest > root) root++;
                res.magnitude = root[gvp_pkg::MAG_W-1:0];

                if (ax == 0) begin
                    res.angle_degrees = gvp_pkg::ANG_W'(90 << FRAC);
                end else if (ay != 0) begin
                    x = ax <<< PRE_SCALE;
                    y = ay <<< PRE_SCALE;
                    z = 0;
                    for (int i = 0; i < ROT_STEPS; i++) begin
                        xs = x >>> i;   // floors on negatives
                        ys = y >>> i;
                        if (y >= 0) begin
                            x += ys;
                            y -= xs;
                            z += atan_q24[i];
                        end else begin
                            x -= ys;
                            y += xs;
                            z -= atan_q24[i];
                        end
                    end
                    if (z < 0) z = 0;
                    if (z > (longint'(90) <<< Z_FRAC)) z = longint'(90) <<< Z_FRAC;
                    uz = z;
                    uz = (uz + (64'd1 << (Z_FRAC - FRAC - 1))) >> (Z_FRAC - FRAC);
                    res.angle_degrees = uz[gvp_pkg::ANG_W-1:0];
                end
            end
            return res;
        endfunction

        function void note_coords(logic [CW-1:0] ox, logic [CW-1:0] oy,
                                  logic [CW-1:0] px, logic [CW-1:0] py);
            pending_polar.push_back(predict_polar(ox, oy, px, py));
        endfunction

        function void check_polar(polar_t got);
            polar_t exp_r;
            if (pending_polar.size() == 0) begin
                $error("result transaction with nothing expected");
                fail_count++;
                return;
            end
            exp_r = pending_polar.pop_front();
            if (got.delta_x !== exp_r.delta_x) begin
                $error("delta_x: expected %0d, got %0d", exp_r.delta_x, got.delta_x);
                fail_count++;
            end
            if (got.delta_y !== exp_r.delta_y) begin
                $error("delta_y: expected %0d, got %0d", exp_r.delta_y, got.delta_y);
                fail_count++;
            end
            if (got.magnitude !== exp_r.magnitude) begin
                $error("magnitude: expected %0d, got %0d", exp_r.magnitude, got.magnitude);
                fail_count++;
            end
            if (got.angle_degrees !== exp_r.angle_degrees) begin
                $error("angle_degrees: expected %0d, got %0d",
                       exp_r.angle_degrees, got.angle_degrees);
                fail_count++;
            end
            if (got.zero_vector !== exp_r.zero_vector) begin
                $error("zero_vector: expected %0d, got %0d",
                       exp_r.zero_vector, got.zero_vector);
                fail_count++;
            end
        endfunction
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [CW-1:0]                      s_origin_x;
    logic [CW-1:0]                      s_origin_y;
    logic [CW-1:0]                      s_dest_x;
    logic [CW-1:0]                      s_dest_y;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [gvp_pkg::DELTA_W-1:0] m_delta_x;
    logic signed [gvp_pkg::DELTA_W-1:0] m_delta_y;
    logic [gvp_pkg::MAG_W-1:0]          m_magnitude;
    logic [gvp_pkg::ANG_W-1:0]          m_angle_degrees;
    logic                               m_zero_vector;

    polar_scoreboard sb = new();
    bit              idle_on;

    grid_vector_to_polar i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_origin_x      (s_origin_x),
        .s_origin_y      (s_origin_y),
        .s_dest_x        (s_dest_x),
        .s_dest_y        (s_dest_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_delta_x       (m_delta_x),
        .m_delta_y       (m_delta_y),
        .m_magnitude     (m_magnitude),
        .m_angle_degrees (m_angle_degrees),
        .m_zero_vector   (m_zero_vector)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result monitor
    always @(posedge aclk) begin
        polar_t got;
        if (aresetn && m_valid && m_ready) begin
            got.delta_x       = m_delta_x;
            got.delta_y       = m_delta_y;
            got.magnitude     = m_magnitude;
            got.angle_degrees = m_angle_degrees;
            got.zero_vector   = m_zero_vector;
            sb.check_polar(got);
        end
    end

    // result side back-pressure in bursts
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_coords(input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                               input logic [CW-1:0] px, input logic [CW-1:0] py);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_origin_x <= ox;
        s_origin_y <= oy;
        s_dest_x   <= px;
        s_dest_y   <= py;
        do @(posedge aclk); while (!s_ready);
        sb.note_coords(ox, oy, px, py);
    endtask

    // hold off the input until every pending transaction has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending_polar.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        logic [CW-1:0] ox, oy, px, py;
        int            kind;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            ox = CW'($urandom);
            oy = CW'($urandom);
            px = CW'($urandom);
            py = CW'($urandom);
            if (kind == 0) begin
                // same point, or one axis shared
                case ($urandom_range(0, 2))
                    0: begin px = ox; py = oy; end
                    1: px = ox;
                    default: py = oy;
                endcase
            end else if (kind <= 2) begin
                // short vectors, near the axes and diagonals
                px = ox + CW'($urandom_range(0, 6)) - CW'(3);
                py = oy + CW'($urandom_range(0, 6)) - CW'(3);
            end
            send_coords(ox, oy, px, py);
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_origin_x = '0;
        s_origin_y = '0;
        s_dest_x   = '0;
        s_dest_y   = '0;
        idle_on    = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_coords(8'd0,   8'd0,   8'd0,   8'd0);     // zero vector at origin
        send_coords(8'd173, 8'd42,  8'd173, 8'd42);    // zero vector elsewhere
        send_coords(8'd0,   8'd0,   8'd255, 8'd255);
        send_coords(8'd255, 8'd255, 8'd0,   8'd0);
        send_coords(8'd0,   8'd255, 8'd255, 8'd0);
        send_coords(8'd255, 8'd0,   8'd0,   8'd255);
        send_coords(8'd0,   8'd0,   8'd255, 8'd0);     // dy zero
        send_coords(8'd255, 8'd9,   8'd0,   8'd9);
        send_coords(8'd0,   8'd0,   8'd0,   8'd255);   // dx zero
        send_coords(8'd77,  8'd255, 8'd77,  8'd0);
        send_coords(8'd0,   8'd0,   8'd1,   8'd1);     // 45 degrees
        send_coords(8'd5,   8'd5,   8'd4,   8'd6);
        send_coords(8'd0,   8'd0,   8'd255, 8'd1);     // near 0 degrees
        send_coords(8'd0,   8'd0,   8'd1,   8'd255);   // near 90 degrees
        send_coords(8'd128, 8'd128, 8'd127, 8'd129);
        send_coords(8'd100, 8'd50,  8'd101, 8'd50);
        send_coords(8'd170, 8'd85,  8'd85,  8'd170);
        send_coords(8'd0,   8'd0,   8'd3,   8'd4);
        drain_results();

        send_random(150);
        drain_results();
        idle_on = 1'b0;
        send_random(50);
        idle_on = 1'b1;
        send_random(100);
        idle_on = 1'b0;
        send_random(100);

        s_valid <= 1'b0;
        while (sb.pending_polar.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.fail_count == 0 && sb.pending_polar.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
